// ===== sv/tvic_pkg.sv =====
package tvic_pkg;

  localparam int unsigned TIME_BITS = 24;
  localparam int unsigned QUEUE_DEPTH_DEF = 8;

  localparam logic [1:0] KIND_A = 2'd0;
  localparam logic [1:0] KIND_B = 2'd1;
  localparam logic [1:0] KIND_END = 2'd2;

  localparam logic [1:0] MODE_AND = 2'd0;
  localparam logic [1:0] MODE_OR = 2'd1;

  localparam logic [1:0] VAL_FALSE = 2'd0;
  localparam logic [1:0] VAL_UNKNOWN = 2'd2;

  typedef struct packed {
    logic [1:0]           kind;
    logic [1:0]           value;
    logic [TIME_BITS-1:0] seg_start;
    logic [TIME_BITS-1:0] seg_end;
  } tvic_in_t;

  typedef struct packed {
    logic [1:0]           out_value;
    logic [TIME_BITS-1:0] out_start;
    logic [TIME_BITS-1:0] out_end;
    logic                 last;
    logic                 empty_result;
    logic                 overflow;
  } tvic_out_t;

  typedef struct packed {
    logic [1:0]           value;
    logic [TIME_BITS-1:0] seg_start;
    logic [TIME_BITS-1:0] seg_end;
  } tvic_seg_t;

  typedef struct packed {
    logic      push;
    logic      pop;
    logic      clr;
    tvic_seg_t wseg;
  } tvic_qcmd_t;

  function automatic logic [1:0] tvic_combine(input logic [1:0] mode,
                                              input logic [1:0] v1,
                                              input logic [1:0] v2);
    logic [1:0] r;
    case (mode)
      MODE_AND: begin
        if (v1 != VAL_FALSE && v2 != VAL_FALSE) r = (v1 > v2) ? v1 : v2;
        else r = VAL_FALSE;
      end
      MODE_OR: begin
        if (v1 != VAL_FALSE && v2 != VAL_FALSE) r = (v1 < v2) ? v1 : v2;
        else if (v1 != VAL_FALSE) r = v1;
        else r = v2;
      end
      default: r = (v1 == VAL_UNKNOWN) ? v2 : v1;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/tvic_queue.sv =====
module tvic_queue import tvic_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  localparam int unsigned Depth = QUEUE_DEPTH + 1,
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tvic_qcmd_t      cmd_i,
  output logic [CntW-1:0] count_o,
  output tvic_seg_t       head_o
);

  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned SumW = $clog2(2 * Depth);

  tvic_seg_t       mem_q [Depth];
  tvic_seg_t       rdata_q;
  logic [IdxW-1:0] head_q, head_d;
  logic [CntW-1:0] count_q, count_d;
  logic [SumW-1:0] tail_sum;
  logic [IdxW-1:0] tail;

  // circular buffer of Depth entries, tail wraps past the last slot
  assign tail_sum = SumW'(head_q) + SumW'(count_q);
  always_comb begin
    if (tail_sum >= SumW'(Depth)) tail = IdxW'(tail_sum - SumW'(Depth));
    else tail = IdxW'(tail_sum);
  end

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (cmd_i.clr) begin
      head_d  = '0;
      count_d = '0;
    end else if (cmd_i.push) begin
      count_d = count_q + CntW'(1);
    end else if (cmd_i.pop) begin
      head_d  = (head_q == IdxW'(Depth - 1)) ? '0 : head_q + IdxW'(1);
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push && !cmd_i.clr) mem_q[tail] <= cmd_i.wseg;
    rdata_q <= mem_q[head_q];
  end

  assign count_o = count_q;
  assign head_o  = rdata_q;

endmodule

// ===== sv/three_valued_interval_combiner.sv =====
// Segment item: optional gap filler write, segment write, head check, then a compare
// and head check per pair of heads; a dropped item emits an overflow result. Each
// queue memory's single write port and registered read set these steps. An end item
// pads the earlier operand if needed, compares alike, then emits the final result.
// A result sits in an output register and holds under stall. Reset (asynchronous,
// active low) empties both queues, drops the held result, sets mode three-valued and.
module three_valued_interval_combiner import tvic_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  tvic_in_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output tvic_out_t  out_data_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 2);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_GAP  = 3'd1;
  localparam logic [2:0] S_SEG  = 3'd2;
  localparam logic [2:0] S_PAD  = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_EV   = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;
  localparam logic [2:0] S_OVF  = 3'd7;

  logic [2:0]           state_q, state_d;
  logic [1:0]           op_mode_q;
  logic                 sel_b_q, sel_b_d;
  logic                 is_end_q, is_end_d;
  tvic_seg_t            item_q, item_d;
  tvic_seg_t            fill_q, fill_d;
  logic [TIME_BITS-1:0] last_end_a_q, last_end_a_d;
  logic [TIME_BITS-1:0] last_end_b_q, last_end_b_d;
  tvic_seg_t            held_q, held_d;
  logic                 held_valid_q, held_valid_d;
  logic                 out_valid_q;
  tvic_out_t            out_q;

  tvic_qcmd_t      qa_cmd, qb_cmd;
  logic [CntW-1:0] cnt_a, cnt_b;
  tvic_seg_t       head_a, head_b;

  logic                 can_emit, emit_req;
  tvic_out_t            emit_data;
  logic                 push, pop_a, pop_b, clr;
  tvic_seg_t            wseg;
  logic [TIME_BITS-1:0] le, fin, ov_start, ov_end;
  logic [CntW-1:0]      cnt;
  logic                 gap, hit, fuse;
  logic [1:0]           cv;

  tvic_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (qa_cmd),
    .count_o (cnt_a),
    .head_o  (head_a)
  );

  tvic_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (qb_cmd),
    .count_o (cnt_b),
    .head_o  (head_b)
  );

  assign can_emit   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);

  assign le   = (in_data_i.kind == KIND_B) ? last_end_b_q : last_end_a_q;
  assign cnt  = (in_data_i.kind == KIND_B) ? cnt_b : cnt_a;
  assign gap  = in_data_i.seg_start > le;
  assign fin  = (last_end_a_q > last_end_b_q) ? last_end_a_q : last_end_b_q;

  assign ov_start = (head_a.seg_start > head_b.seg_start) ? head_a.seg_start
                                                          : head_b.seg_start;
  assign ov_end   = (head_a.seg_end < head_b.seg_end) ? head_a.seg_end : head_b.seg_end;
  assign hit      = ov_start < ov_end;
  assign cv       = tvic_combine(op_mode_q, head_a.value, head_b.value);
  assign fuse     = held_valid_q && (held_q.value == cv);

  always_comb begin
    state_d      = state_q;
    sel_b_d      = sel_b_q;
    is_end_d     = is_end_q;
    item_d       = item_q;
    fill_d       = fill_q;
    last_end_a_d = last_end_a_q;
    last_end_b_d = last_end_b_q;
    held_d       = held_q;
    held_valid_d = held_valid_q;
    emit_req     = 1'b0;
    emit_data    = '0;
    push         = 1'b0;
    pop_a        = 1'b0;
    pop_b        = 1'b0;
    clr          = 1'b0;
    wseg         = fill_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          sel_b_d  = (in_data_i.kind == KIND_B);
          is_end_d = (in_data_i.kind == KIND_END);
          item_d   = '{value: in_data_i.value, seg_start: in_data_i.seg_start,
                       seg_end: in_data_i.seg_end};
          fill_d   = '{value: VAL_UNKNOWN, seg_start: le, seg_end: in_data_i.seg_start};
          unique case (in_data_i.kind) inside
            KIND_A, KIND_B: begin
              if ((CntW+1)'(cnt) + (gap ? (CntW+1)'(2) : (CntW+1)'(1))
                  > (CntW+1)'(QUEUE_DEPTH)) begin
                state_d = S_OVF;
              end else begin
                state_d = gap ? S_GAP : S_SEG;
              end
            end
            KIND_END: begin
              // pad the operand that finished earlier up to the later end
              if (last_end_a_q < fin) begin
                sel_b_d = 1'b0;
                fill_d  = '{value: VAL_UNKNOWN, seg_start: last_end_a_q, seg_end: fin};
                state_d = S_PAD;
              end else if (last_end_b_q < fin) begin
                sel_b_d = 1'b1;
                fill_d  = '{value: VAL_UNKNOWN, seg_start: last_end_b_q, seg_end: fin};
                state_d = S_PAD;
              end else begin
                state_d = S_RD;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_GAP: begin
        push    = 1'b1;
        state_d = S_SEG;
      end
      S_SEG: begin
        push = 1'b1;
        wseg = item_q;
        if (sel_b_q) last_end_b_d = item_q.seg_end;
        else last_end_a_d = item_q.seg_end;
        state_d = S_RD;
      end
      S_PAD: begin
        push    = 1'b1;
        state_d = S_RD;
      end
      S_RD: begin
        if (cnt_a != '0 && cnt_b != '0) state_d = S_EV;
        else if (is_end_q) state_d = S_FIN;
        else state_d = S_IDLE;
      end
      S_EV: begin
        // hold the heads while the displaced result cannot leave
        if (!(hit && held_valid_q && !fuse && !can_emit)) begin
          if (hit) begin
            if (fuse) begin
              held_d.seg_end = ov_end;
            end else begin
              emit_req     = held_valid_q;
              emit_data    = '{out_value: held_q.value, out_start: held_q.seg_start,
                               out_end: held_q.seg_end, default: 1'b0};
              held_d       = '{value: cv, seg_start: ov_start, seg_end: ov_end};
              held_valid_d = 1'b1;
            end
          end
          if (head_a.seg_end <= head_b.seg_end) pop_a = 1'b1;
          else pop_b = 1'b1;
          state_d = S_RD;
        end
      end
      S_FIN: begin
        if (can_emit) begin
          emit_req = 1'b1;
          if (held_valid_q) begin
            emit_data = '{out_value: held_q.value, out_start: held_q.seg_start,
                          out_end: held_q.seg_end, last: 1'b1, default: 1'b0};
          end else begin
            emit_data.empty_result = 1'b1;
          end
          clr          = 1'b1;
          last_end_a_d = '0;
          last_end_b_d = '0;
          held_d       = '0;
          held_valid_d = 1'b0;
          is_end_d     = 1'b0;
          state_d      = S_IDLE;
        end
      end
      S_OVF: begin
        if (can_emit) begin
          emit_req           = 1'b1;
          emit_data.overflow = 1'b1;
          state_d            = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    qa_cmd      = '0;
    qb_cmd      = '0;
    qa_cmd.wseg = wseg;
    qb_cmd.wseg = wseg;
    qa_cmd.push = push && !sel_b_q;
    qb_cmd.push = push && sel_b_q;
    qa_cmd.pop  = pop_a;
    qb_cmd.pop  = pop_b;
    qa_cmd.clr  = clr;
    qb_cmd.clr  = clr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      op_mode_q    <= MODE_AND;
      sel_b_q      <= 1'b0;
      is_end_q     <= 1'b0;
      last_end_a_q <= '0;
      last_end_b_q <= '0;
      held_q       <= '0;
      held_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      sel_b_q      <= sel_b_d;
      is_end_q     <= is_end_d;
      last_end_a_q <= last_end_a_d;
      last_end_b_q <= last_end_b_d;
      held_q       <= held_d;
      held_valid_q <= held_valid_d;
      if (cfg_we_i) op_mode_q <= cfg_wdata_i;
      if (can_emit) out_valid_q <= emit_req;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    fill_q <= fill_d;
    if (can_emit && emit_req) out_q <= emit_data;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  // drain leaves at least one operand queue empty
  a_idle_one_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (cnt_a == '0 || cnt_b == '0))
    else $error("both queues hold segments while idle");

  a_eval_both_heads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EV) |-> (cnt_a != '0 && cnt_b != '0))
    else $error("compare without a head in both queues");

  a_fin_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && can_emit) |=> (!held_valid_q && cnt_a == '0 && cnt_b == '0))
    else $error("end item left state behind");

  a_out_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0({out_data_o.last, out_data_o.empty_result,
                              out_data_o.overflow}))
    else $error("more than one result flag set");
`endif

endmodule
